// ===== hw/rtl/ntg_pkg.sv =====
package ntg_pkg;

  localparam int unsigned DivStages     = 4;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned NumLanes      = 4;

  localparam int unsigned LaneLeft   = 0;
  localparam int unsigned LaneRight  = 1;
  localparam int unsigned LaneTop    = 2;
  localparam int unsigned LaneBottom = 3;

  localparam logic [3:0] TileWhole = 4'd9;
  localparam logic [3:0] TileLast  = 4'd8;
  localparam logic [1:0] PosFirst  = 2'd0;
  localparam logic [1:0] PosMid    = 2'd1;
  localparam logic [1:0] PosLast   = 2'd2;

  typedef struct packed {
    logic [11:0]        src_x;
    logic [11:0]        src_y;
    logic [11:0]        src_w;
    logic [11:0]        src_h;
    logic [7:0]         border_left;
    logic [7:0]         border_right;
    logic [7:0]         border_top;
    logic [7:0]         border_bottom;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic [11:0]        dst_w;
    logic [11:0]        dst_h;
  } req_t;

  typedef struct packed {
    req_t                        req;
    logic                        whole;
    logic                        need_h;
    logic                        need_v;
    logic [8:0]                  div_h;
    logic [8:0]                  div_v;
    logic [NumLanes-1:0][16:0]   acc;
  } stage_t;

  typedef struct packed {
    logic [13:0] src_x;
    logic [13:0] src_y;
    logic [13:0] src_w;
    logic [13:0] src_h;
    logic [16:0] dst_x;
    logic [16:0] dst_y;
    logic [11:0] dst_w;
    logic [11:0] dst_h;
    logic [3:0]  index;
    logic        last;
  } tile_t;

  // one restoring division step, upper nine bits hold the partial remainder
  function automatic logic [16:0] div_step(logic [16:0] acc, logic [8:0] d);
    logic [9:0] tr;
    logic [9:0] diff;
    tr   = acc[16:7];
    diff = tr - {1'b0, d};
    if (tr >= {1'b0, d}) begin
      return {diff[8:0], acc[6:0], 1'b1};
    end else begin
      return {tr[8:0], acc[6:0], 1'b0};
    end
  endfunction

endpackage

// ===== hw/rtl/nine_patch_tile_geometry.sv =====
// path: entry register, four divider stages, tile registers, output register
// a bordered request yields nine tiles and a zero-border request one tile,
// issued by the tile sequencer one tile per cycle unless the output port stalls
// border scaling runs in a 4-stage divider pipeline, 2 quotient bits per stage
// reset: asynchronous active-low reset clears all valid bits and tile counters
module nine_patch_tile_geometry #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // src_x, src_y, src_w, src_h, border_left, border_right, border_top,
  // border_bottom, dst_x, dst_y, dst_w, dst_h
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tile_src_x, tile_src_y, tile_src_w, tile_src_h, tile_dst_x, tile_dst_y,
  // tile_dst_w, tile_dst_h, zero pad
  output logic [119:0] m_axis_tdata,
  // tile_index
  output logic [3:0]   m_axis_tuser,
  // last_tile
  output logic         m_axis_tlast
);

  ntg_pkg::req_t  in_req;
  ntg_pkg::req_t  sc_req;
  ntg_pkg::tile_t tile;
  logic           sc_valid, sc_ready, sc_whole;

  always_comb begin
    in_req.src_x         = s_axis_tdata[11:0];
    in_req.src_y         = s_axis_tdata[23:12];
    in_req.src_w         = s_axis_tdata[35:24];
    in_req.src_h         = s_axis_tdata[47:36];
    in_req.border_left   = s_axis_tdata[55:48];
    in_req.border_right  = s_axis_tdata[63:56];
    in_req.border_top    = s_axis_tdata[71:64];
    in_req.border_bottom = s_axis_tdata[79:72];
    in_req.dst_x         = s_axis_tdata[95:80];
    in_req.dst_y         = s_axis_tdata[111:96];
    in_req.dst_w         = s_axis_tdata[123:112];
    in_req.dst_h         = s_axis_tdata[135:124];
  end

  ntg_scale #(
    .COORD_BITS(COORD_BITS)
  ) u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_req_i   (in_req),
    .out_valid_o(sc_valid),
    .out_ready_i(sc_ready),
    .out_req_o  (sc_req),
    .out_whole_o(sc_whole)
  );

  ntg_tile u_tile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sc_valid),
    .in_ready_o (sc_ready),
    .in_req_i   (sc_req),
    .in_whole_i (sc_whole),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_tile_o (tile)
  );

  assign m_axis_tdata = {6'd0, tile.dst_h, tile.dst_w, tile.dst_y, tile.dst_x,
                         tile.src_h, tile.src_w, tile.src_y, tile.src_x};
  assign m_axis_tuser = tile.index;
  assign m_axis_tlast = tile.last;

endmodule

// ===== hw/rtl/ntg_scale.sv =====
module ntg_scale #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ntg_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ntg_pkg::req_t out_req_o,
  output logic          out_whole_o
);

  localparam int unsigned NS = ntg_pkg::DivStages;
  localparam logic [16:0] CmaskWide = (17'd1 << COORD_BITS) - 17'd1;
  localparam logic [11:0] Cmask = CmaskWide[11:0];

  ntg_pkg::stage_t st_q [NS+1];
  ntg_pkg::stage_t st_nxt [NS+1];
  logic [NS:0]     vld_q;
  logic [NS:0]     en;
  ntg_pkg::req_t   req_m;
  logic [8:0]      sum_h;
  logic [8:0]      sum_v;
  logic [19:0]     prod [ntg_pkg::NumLanes];

  function automatic ntg_pkg::stage_t advance(ntg_pkg::stage_t s);
    ntg_pkg::stage_t o;
    o = s;
    for (int st = 0; st < ntg_pkg::StepsPerStage; st++) begin
      o.acc[ntg_pkg::LaneLeft]   = ntg_pkg::div_step(o.acc[ntg_pkg::LaneLeft], o.div_h);
      o.acc[ntg_pkg::LaneRight]  = ntg_pkg::div_step(o.acc[ntg_pkg::LaneRight], o.div_h);
      o.acc[ntg_pkg::LaneTop]    = ntg_pkg::div_step(o.acc[ntg_pkg::LaneTop], o.div_v);
      o.acc[ntg_pkg::LaneBottom] = ntg_pkg::div_step(o.acc[ntg_pkg::LaneBottom], o.div_v);
    end
    return o;
  endfunction

  // entry: coordinate mask, border sums and products
  always_comb begin
    req_m       = in_req_i;
    req_m.src_x = in_req_i.src_x & Cmask;
    req_m.src_y = in_req_i.src_y & Cmask;
    req_m.src_w = in_req_i.src_w & Cmask;
    req_m.src_h = in_req_i.src_h & Cmask;
    req_m.dst_w = in_req_i.dst_w & Cmask;
    req_m.dst_h = in_req_i.dst_h & Cmask;
    sum_h = 9'(req_m.border_left) + 9'(req_m.border_right);
    sum_v = 9'(req_m.border_top) + 9'(req_m.border_bottom);
    prod[ntg_pkg::LaneLeft]   = 20'(req_m.dst_w) * 20'(req_m.border_left);
    prod[ntg_pkg::LaneRight]  = 20'(req_m.dst_w) * 20'(req_m.border_right);
    prod[ntg_pkg::LaneTop]    = 20'(req_m.dst_h) * 20'(req_m.border_top);
    prod[ntg_pkg::LaneBottom] = 20'(req_m.dst_h) * 20'(req_m.border_bottom);
    st_nxt[0].req    = req_m;
    st_nxt[0].whole  = (sum_h == 9'd0) && (sum_v == 9'd0);
    st_nxt[0].need_h = req_m.dst_w < 12'(sum_h);
    st_nxt[0].need_v = req_m.dst_h < 12'(sum_v);
    st_nxt[0].div_h  = sum_h;
    st_nxt[0].div_v  = sum_v;
    for (int l = 0; l < ntg_pkg::NumLanes; l++) begin
      st_nxt[0].acc[l] = prod[l][16:0];
    end
    for (int k = 1; k <= NS; k++) begin
      st_nxt[k] = advance(st_q[k-1]);
    end
  end

  always_comb begin
    en[NS] = !vld_q[NS] || out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NS];
  assign out_whole_o = st_q[NS].whole;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= NS; k++) begin
      if (en[k]) st_q[k] <= st_nxt[k];
    end
  end

  always_comb begin
    out_req_o = st_q[NS].req;
    if (st_q[NS].need_h) begin
      out_req_o.border_left  = st_q[NS].acc[ntg_pkg::LaneLeft][7:0];
      out_req_o.border_right = st_q[NS].acc[ntg_pkg::LaneRight][7:0];
    end
    if (st_q[NS].need_v) begin
      out_req_o.border_top    = st_q[NS].acc[ntg_pkg::LaneTop][7:0];
      out_req_o.border_bottom = st_q[NS].acc[ntg_pkg::LaneBottom][7:0];
    end
  end

endmodule

// ===== hw/rtl/ntg_tile.sv =====
module ntg_tile (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ntg_pkg::req_t  in_req_i,
  input  logic           in_whole_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ntg_pkg::tile_t out_tile_o
);

  typedef struct packed {
    logic [2:0][13:0] spos;
    logic [2:0][13:0] ssize;
    logic [2:0][16:0] dpos;
    logic [2:0][11:0] dsize;
  } axis_t;

  function automatic axis_t make_axis(logic [11:0] p, logic [11:0] s, logic [7:0] lo,
                                      logic [7:0] hi, logic [15:0] dp, logic [11:0] ds);
    axis_t a;
    logic [16:0] dpx;
    dpx = {dp[15], dp};
    a.spos[0]  = 14'(p);
    a.spos[1]  = 14'(p) + 14'(lo);
    a.spos[2]  = 14'(p) + 14'(s) - 14'(hi);
    a.ssize[0] = 14'(lo);
    a.ssize[1] = 14'(s) - 14'(lo) - 14'(hi);
    a.ssize[2] = 14'(hi);
    a.dpos[0]  = dpx;
    a.dpos[1]  = dpx + 17'(lo);
    a.dpos[2]  = dpx + 17'(ds) - 17'(hi);
    a.dsize[0] = 12'(lo);
    a.dsize[1] = ds - 12'(lo) - 12'(hi);
    a.dsize[2] = 12'(hi);
    return a;
  endfunction

  axis_t          col_q, row_q;
  logic           whole_q, g_vld_q;
  logic [1:0]     c_q, r_q;
  logic [3:0]     idx_q;
  logic           out_vld_q;
  ntg_pkg::tile_t out_q;
  ntg_pkg::tile_t cur;
  logic           adv, load, whole_in;

  // decided on the borders as requested, before any scaling
  assign whole_in = in_whole_i;

  always_comb begin
    cur.src_x = col_q.spos[c_q];
    cur.src_w = col_q.ssize[c_q];
    cur.dst_x = col_q.dpos[c_q];
    cur.dst_w = col_q.dsize[c_q];
    cur.src_y = row_q.spos[r_q];
    cur.src_h = row_q.ssize[r_q];
    cur.dst_y = row_q.dpos[r_q];
    cur.dst_h = row_q.dsize[r_q];
    cur.index = whole_q ? ntg_pkg::TileWhole : idx_q;
    cur.last  = whole_q || (idx_q == ntg_pkg::TileLast);
  end

  assign adv        = g_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !g_vld_q || (adv && cur.last);
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q   <= 1'b0;
      whole_q   <= 1'b0;
      c_q       <= ntg_pkg::PosFirst;
      r_q       <= ntg_pkg::PosFirst;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (load) begin
        g_vld_q <= 1'b1;
        whole_q <= whole_in;
        c_q     <= whole_in ? ntg_pkg::PosMid : ntg_pkg::PosFirst;
        r_q     <= whole_in ? ntg_pkg::PosMid : ntg_pkg::PosFirst;
        idx_q   <= '0;
      end else if (adv) begin
        if (cur.last) begin
          g_vld_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 4'd1;
          if (c_q == ntg_pkg::PosLast) begin
            c_q <= ntg_pkg::PosFirst;
            r_q <= r_q + 2'd1;
          end else begin
            c_q <= c_q + 2'd1;
          end
        end
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      col_q <= make_axis(in_req_i.src_x, in_req_i.src_w, in_req_i.border_left,
                         in_req_i.border_right, in_req_i.dst_x, in_req_i.dst_w);
      row_q <= make_axis(in_req_i.src_y, in_req_i.src_h, in_req_i.border_top,
                         in_req_i.border_bottom, in_req_i.dst_y, in_req_i.dst_h);
    end
    if (adv) out_q <= cur;
  end

  assign out_valid_o = out_vld_q;
  assign out_tile_o  = out_q;

endmodule
